>>> rtl/seeded_hop_permutation_assert.svh
// Assertion macros used by the hop sequencer module
`ifndef SEEDED_HOP_PERMUTATION_ASSERT_SVH
`define SEEDED_HOP_PERMUTATION_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SHP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants of the seeded hop permutation sequencer.
// ----------------------------------------------------------------------------
package shp_pkg;
	localparam int MaxChannels = 64;
	localparam int AddrW = $clog2(MaxChannels);

	localparam logic [1:0] RegSeed  = 2'd0;
	localparam logic [1:0] RegSubst = 2'd1;
	localparam logic [1:0] RegBase  = 2'd2;
	localparam logic [1:0] RegTotal = 2'd3;

	localparam logic KindRebuild = 1'b0;
	localparam logic KindLookup  = 1'b1;

	localparam logic StatusOk  = 1'b0;
	localparam logic StatusBad = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FILL,
		ST_GEN,
		ST_DIV,
		ST_RDA,
		ST_RDB,
		ST_WRA,
		ST_LDIV,
		ST_LRD,
		ST_LWAIT,
		ST_OUT
	} state_t;

	// divider request / answer between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [8:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic       busy;
		logic [8:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] xs_next(input logic [31:0] x);
		logic [31:0] a;
		logic [31:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction
endpackage

>>> rtl/seeded_hop_permutation.sv
// ----------------------------------------------------------------------------
// seeded_hop_permutation
// Frequency-hop channel sequencer with a seeded shuffled channel table.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid, in_stall, kind, slot_number | to block
//  out     | out_valid, out_stall, channel, status | from block
//  cfg     | cfg_we, cfg_index, cfg_data           | to block
// Reset clears all 64 table entries in one pass; no item is taken meanwhile.
// Lookup: accept starts the bit-serial 64-bit remainder unit; a table read
// at the remainder follows, and then out_valid.
// Rebuild: a fill pass writes base+i to entries below count, then each swap
// takes a remainder, two reads and two writes (one read, one write port).
// One item at a time; a result held by out_stall blocks the next item.
`include "seeded_hop_permutation_assert.svh"

module seeded_hop_permutation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [63:0] slot_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  channel,
	output logic        status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import shp_pkg::*;

	logic [31:0] seed_q, subst_q;
	logic [7:0]  base_q;
	logic [8:0]  total_q;

	state_t      state_q, state_d;
	logic [8:0]  i_q;
	logic [31:0] gen_q;
	logic [AddrW-1:0] j_q;
	logic [7:0]  va_q;
	logic [7:0]  ch_q;
	logic        st_q;
	logic        ovalid_q;
	logic        count_ok;
	logic        accept;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic             we;
	logic [AddrW-1:0] waddr, raddr;
	logic [7:0]       wdata, rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			subst_q <= 32'd1;
			base_q  <= '0;
			total_q <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegSeed:  seed_q  <= cfg_data;
				RegSubst: subst_q <= cfg_data;
				RegBase:  base_q  <= cfg_data[7:0];
				RegTotal: total_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign count_ok = (total_q != 9'd0) && (total_q <= 9'(MaxChannels));
	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign accept   = in_valid && !in_stall;

	shp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	shp_table u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (i_q == 9'(MaxChannels - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (!count_ok) state_d = ST_OUT;
					else if (kind == KindRebuild) state_d = ST_FILL;
					else state_d = ST_LDIV;
				end
			end
			ST_FILL: begin
				if (i_q + 9'd1 == total_q) begin
					state_d = (total_q > 9'd2) ? ST_GEN : ST_OUT;
				end
			end
			ST_GEN:  state_d = ST_DIV;
			ST_DIV:  if (!drsp.busy && !dreq.start) state_d = ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_WRA;
			ST_WRA:  state_d = (i_q == 9'd3) ? ST_OUT : ST_GEN;
			ST_LDIV: if (!drsp.busy && !dreq.start) state_d = ST_LRD;
			ST_LRD:  state_d = ST_LWAIT;
			ST_LWAIT: state_d = ST_OUT;
			ST_OUT:  if (!ovalid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs to divider and table
	always_comb begin
		dreq  = '0;
		we    = 1'b0;
		waddr = i_q[AddrW-1:0];
		wdata = '0;
		raddr = i_q[AddrW-1:0] - AddrW'(1);
		unique case (state_q)
			ST_CLEAR: we = 1'b1;
			ST_FILL: begin
				we    = 1'b1;
				wdata = base_q + i_q[7:0];
			end
			ST_GEN: begin
				dreq.start    = 1'b1;
				dreq.dividend = {32'd0, xs_next(gen_q)};
				dreq.divisor  = i_q - 9'd1;
			end
			ST_RDA: raddr = j_q;
			ST_RDB: begin
				// va_q holds entry i-1; write it to j
				we    = 1'b1;
				waddr = j_q;
				wdata = va_q;
			end
			ST_WRA: begin
				we    = 1'b1;
				waddr = i_q[AddrW-1:0] - AddrW'(1);
				wdata = va_q;
			end
			ST_IDLE: begin
				dreq.start    = accept && count_ok && (kind == KindLookup);
				dreq.dividend = slot_number;
				dreq.divisor  = total_q;
			end
			ST_LRD: raddr = drsp.rem[AddrW-1:0];
			default: ;
		endcase
	end

	// raddr in ST_DIV defaults to entry i-1, so rdata is entry i-1 in ST_RDA
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			i_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_FILL) begin
				i_q <= i_q + 9'd1;
			end
			if (state_q == ST_CLEAR && state_d == ST_IDLE) i_q <= '0;
			if (accept) i_q <= '0;
			if (state_q == ST_FILL && state_d == ST_GEN) i_q <= total_q;
			if (state_q == ST_WRA) i_q <= i_q - 9'd1;
			if (state_q != ST_OUT && state_d == ST_OUT) ovalid_q <= 1'b1;
			else if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gen_q <= (seed_q != 32'd0) ? seed_q : subst_q;
			ch_q  <= '0;
			st_q  <= count_ok ? StatusOk : StatusBad;
		end
		if (state_q == ST_GEN) gen_q <= xs_next(gen_q);
		if (state_q == ST_DIV && state_d == ST_RDA) j_q <= AddrW'(drsp.rem + 9'd1);
		// entry i-1 first, then entry j before it is overwritten
		if (state_q == ST_RDA) va_q <= rdata;
		if (state_q == ST_RDB) va_q <= rdata;
		if (state_q == ST_LWAIT) ch_q <= rdata;
	end

	assign out_valid = ovalid_q;
	assign channel   = ch_q;
	assign status    = st_q;

	`SHP_ASSERT_IMPL(a_no_take_busy, state_q != ST_IDLE, in_stall, "item taken while busy")
	`SHP_ASSERT_IMPL(a_bad_zero, out_valid && status == StatusBad, channel == 8'd0,
		"nonzero channel on error")
	`SHP_ASSERT_NEXT(a_accept_out, accept && !count_ok, out_valid,
		"error result not posted")
endmodule

>>> rtl/shp_div.sv
// ----------------------------------------------------------------------------
// shp_div
// Bit-serial remainder of a 64-bit value by a 9-bit divisor.
// ----------------------------------------------------------------------------
module shp_div (
	input  logic             clk,
	input  logic             arst_n,
	input  shp_pkg::div_req_t req,
	output shp_pkg::div_rsp_t rsp
);
	import shp_pkg::*;

	logic [63:0] num_q;
	logic [8:0]  den_q;
	logic [9:0]  rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;

	// remainder stays below the divisor, so 10 bits hold the shifted value
	assign trial = {rem_q[8:0], num_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.rem  = rem_q[8:0];
endmodule

>>> rtl/shp_table.sv
// ----------------------------------------------------------------------------
// shp_table
// Hop table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module shp_table (
	input  logic                     clk,
	input  logic                     we,
	input  logic [shp_pkg::AddrW-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic [shp_pkg::AddrW-1:0] raddr,
	output logic [7:0]               rdata
);
	import shp_pkg::*;

	logic [7:0] mem [MaxChannels];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> test/tb_seeded_hop_permutation.sv
// ----------------------------------------------------------------------------
// tb_seeded_hop_permutation
// Self-checking bench for the seeded hop permutation sequencer: a directed
// table of items and register writes, then random phases under several
// register settings; results checked against typed rows or an in-bench table.
// ----------------------------------------------------------------------------
module tb_seeded_hop_permutation;
	import shp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 3000000;
	localparam int unsigned HoldCycles = 700;

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  idx;
		logic [31:0] data;
		logic        kind;
		logic [63:0] slot;
		logic        typed;
		logic [7:0]  ch;
		logic        st;
	} row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       st;
	} hop_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [63:0] slot_number;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  channel;
	logic        status;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// bench copy of the block's registers and table
	logic [31:0] m_seed;
	logic [31:0] m_subst;
	logic [7:0]  m_base;
	logic [8:0]  m_total;
	logic [7:0]  m_table [MaxChannels];

	hop_res_t    pending_q[$];
	int unsigned mismatches;
	int unsigned cycles;
	bit          quiet;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned rx_wait;
	int unsigned items_sent;

	seeded_hop_permutation i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.slot_number(slot_number),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.channel    (channel),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// rebuild or lookup on the bench table, giving the expected result
	task automatic hop_step(input logic k, input logic [63:0] slot, output hop_res_t res);
		logic [31:0] gen;
		logic [31:0] j;
		logic [7:0]  held;
		res = '{ch: 8'd0, st: StatusOk};
		if (m_total == 9'd0 || m_total > MaxChannels) begin
			res.st = StatusBad;
		end else if (k == KindRebuild) begin
			gen = (m_seed != 32'd0) ? m_seed : m_subst;
			for (int i = 0; i < m_total; i++)
				m_table[i] = m_base + 8'(i);
			for (int i = m_total; i > 2; i--) begin
				gen = gen ^ (gen << 13);
				gen = gen ^ (gen >> 17);
				gen = gen ^ (gen << 5);
				j = 32'd1 + gen % 32'(i - 1);
				held = m_table[i - 1];
				m_table[i - 1] = m_table[j];
				m_table[j] = held;
			end
		end else begin
			res.ch = m_table[slot % 64'(m_total)];
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			RegSeed:  m_seed = data;
			RegSubst: m_subst = data;
			RegBase:  m_base = data[7:0];
			RegTotal: m_total = data[8:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// offer one item; valid drops in the step it is taken
	task automatic send(input logic k, input logic [63:0] slot, input bit typed,
			input hop_res_t typed_res);
		hop_res_t res;
		@(posedge clk);
		if (!quiet)
			repeat ($urandom_range(0, 12)) @(posedge clk);
		in_valid <= 1'b1;
		kind <= k;
		slot_number <= slot;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		hop_step(k, slot, res);
		pending_q.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	// result side: random stall per item, plus the long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		hop_res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					report("unexpected item", channel, 8'd0);
				end else begin
					want = pending_q.pop_front();
					if (channel !== want.ch)
						report("channel", channel, want.ch);
					if (status !== want.st)
						report("status", 8'(status), 8'(want.st));
				end
				rx_wait = quiet ? 0 : $urandom_range(0, 12);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic row_t lk(input logic [63:0] slot, input bit typed = 0,
			input logic [7:0] ch = 0, input logic st = StatusOk);
		return '{1'b0, RegSeed, 32'd0, KindLookup, slot, typed, ch, st};
	endfunction

	function automatic row_t rb(input bit typed = 0, input logic st = StatusOk);
		return '{1'b0, RegSeed, 32'd0, KindRebuild, 64'd0, typed, 8'd0, st};
	endfunction

	function automatic row_t cf(input logic [1:0] idx, input logic [31:0] data);
		return '{1'b1, idx, data, KindRebuild, 64'd0, 1'b0, 8'd0, StatusOk};
	endfunction

	row_t dir_rows [34];

	initial begin
		hop_res_t    tres;
		logic [63:0] slot;
		logic [31:0] val;
		int unsigned n;
		int unsigned phase;

		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KindRebuild;
		slot_number = '0;
		cfg_we = 1'b0;
		cfg_index = RegSeed;
		cfg_data = '0;
		hold_req = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		cycles = 0;
		items_sent = 0;
		m_seed = 32'd0;
		m_subst = 32'd1;
		m_base = 8'd0;
		m_total = 9'd1;
		foreach (m_table[i]) m_table[i] = 8'd0;

		dir_rows = '{
			lk(64'd0, 1, 8'd0, StatusOk),          // table after reset
			lk('1, 1, 8'd0, StatusOk),
			rb(1, StatusOk),                        // single channel: no swap
			lk(64'd5),
			cf(RegTotal, 32'd0),
			lk(64'd1, 1, 8'd0, StatusBad),
			rb(1, StatusBad),
			cf(RegTotal, 32'd65),
			lk(64'd7, 1, 8'd0, StatusBad),
			rb(1, StatusBad),
			cf(RegTotal, 32'd256),
			lk('1, 1, 8'd0, StatusBad),
			cf(RegSeed, 32'd0),                     // both seeds zero: j stuck at 1
			cf(RegSubst, 32'd0),
			cf(RegBase, 32'hFF),
			cf(RegTotal, MaxChannels),
			rb(1, StatusOk),
			lk('1),
			lk(64'd63),
			lk(64'd64),
			cf(RegTotal, 32'd2),
			rb(),
			lk(64'd1),
			cf(RegSeed, 32'hFFFF_FFFF),
			cf(RegBase, 32'hFE),                    // channels wrap past 255
			cf(RegTotal, 32'd3),
			rb(),
			lk(64'd2),
			cf(RegSubst, 32'hFFFF_FFFF),
			cf(RegTotal, MaxChannels),
			lk(64'd10),                             // stale table, larger count
			rb(),
			lk(64'd33),
			lk(64'h8000_0000_0000_0001)
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				drain();
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				tres = '{ch: dir_rows[r].ch, st: dir_rows[r].st};
				send(dir_rows[r].kind, dir_rows[r].slot, dir_rows[r].typed, tres);
			end
		end

		phase = 0;
		while (items_sent < 1100) begin
			drain();
			quiet = (phase % 4 == 3);
			case ($urandom_range(0, 3))
				0: val = 32'd0;
				1: val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			write_reg(RegSeed, val);
			write_reg(RegSubst, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
			write_reg(RegBase, $urandom_range(0, 255));
			case ($urandom_range(0, 9))
				0: val = 32'd0;
				1: val = $urandom_range(MaxChannels + 1, 511);
				2, 3: val = MaxChannels;
				default: val = $urandom_range(1, 16);
			endcase
			write_reg(RegTotal, val);
			if (phase == 5)
				hold_req = 1'b1;
			n = $urandom_range(60, 110);
			send(KindRebuild, {$urandom, $urandom}, 0, '0);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: slot = $urandom_range(0, 300);
					default: slot = {$urandom, $urandom};
				endcase
				if ($urandom_range(0, 99) < 4)
					send(KindRebuild, slot, 0, '0);
				else
					send(KindLookup, slot, 0, '0);
			end
			phase++;
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/shp_pkg.sv
rtl/shp_div.sv
rtl/shp_table.sv
rtl/seeded_hop_permutation.sv
test/tb_seeded_hop_permutation.sv
